// ===== src/vmcp_pkg.sv =====
// Package for the min-cost path decoder: item and command types, mode codes,
// table sizes and cost/metric widths. No dependencies.
`timescale 1ns / 1ps
package vmcp_pkg;

  localparam int N_STATES    = 4;
  localparam int N_SYMBOLS   = 4;
  localparam int MAX_LEN_DEF = 64;
  localparam int COST_BITS   = 16;
  localparam int METRIC_BITS = 24;
  localparam int STATE_W     = 2;
  localparam int POS_W       = 6;
  localparam int BP_ROW_W    = N_STATES * STATE_W;

  localparam logic [2:0] MODE_SYMBOL     = 3'd0;
  localparam logic [2:0] MODE_LOAD_SYM   = 3'd1;
  localparam logic [2:0] MODE_LOAD_TRANS = 3'd2;
  localparam logic [2:0] MODE_LOAD_INIT  = 3'd3;
  localparam logic [2:0] MODE_LOAD_FINAL = 3'd4;

  typedef logic signed [COST_BITS-1:0]   cost_t;
  typedef logic signed [METRIC_BITS-1:0] metric_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         symbol;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [15:0] cost_value;
    logic               last_symbol;
  } in_item_t;

  typedef struct packed {
    logic [1:0] label_state;
    logic [5:0] position;
    logic       last_label;
    logic       overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_SYMBOL     = 5'b00001,
    OP_LOAD_SYM   = 5'b00010,
    OP_LOAD_TRANS = 5'b00100,
    OP_LOAD_INIT  = 5'b01000,
    OP_LOAD_FINAL = 5'b10000
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sym;
    logic [1:0] row;
    logic [1:0] col;
    cost_t      cost;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic tracing;
    logic take;
  } back_stat_t;

endpackage

// ===== src/vmcp_front.sv =====
// Front end: accepts input items, decodes the mode and queues commands.
// Depends on vmcp_pkg.
`timescale 1ns / 1ps
module vmcp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  vmcp_pkg::in_item_t in_item,
  output logic               in_full,
  output logic               cmd_valid,
  output vmcp_pkg::cmd_t     cmd,
  input  logic               cmd_take,
  output vmcp_pkg::front_stat_t stat
);
  import vmcp_pkg::*;

  cmd_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       known, enq, deq;

  // Decode mode; reserved modes are dropped here.
  always_comb begin
    known    = 1'b1;
    dec.op   = OP_SYMBOL;
    dec.sym  = in_item.symbol;
    dec.row  = in_item.row_index;
    dec.col  = in_item.col_index;
    dec.cost = cost_t'(in_item.cost_value);
    dec.last = in_item.last_symbol;
    unique case (in_item.mode)
      MODE_SYMBOL:     dec.op = OP_SYMBOL;
      MODE_LOAD_SYM:   dec.op = OP_LOAD_SYM;
      MODE_LOAD_TRANS: dec.op = OP_LOAD_TRANS;
      MODE_LOAD_INIT:  dec.op = OP_LOAD_INIT;
      MODE_LOAD_FINAL: dec.op = OP_LOAD_FINAL;
      default:         known  = 1'b0;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign enq       = in_push && !in_full && known;
  assign deq       = cmd_take && cmd_valid;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign stat.count = cnt_r;

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (enq) begin
        wr_r <= ~wr_r;
      end
      if (deq) begin
        rd_r <= ~rd_r;
      end
      case ({enq, deq})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/vmcp_back.sv =====
// Back end: cost tables, add-compare-select, backpointer memory, traceback
// and the result queue. Depends on vmcp_pkg.
`timescale 1ns / 1ps
module vmcp_back #(
  parameter int MAX_LEN = vmcp_pkg::MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  vmcp_pkg::cmd_t        cmd,
  output logic                  cmd_take,
  output logic                  out_empty,
  input  logic                  out_pop,
  output vmcp_pkg::out_item_t   out_item,
  output vmcp_pkg::back_stat_t  stat
);
  import vmcp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int EXT_W  = METRIC_BITS - COST_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FINAL = 4'b0010,
    ST_PICK  = 4'b0100,
    ST_TRACE = 4'b1000
  } st_t;

  st_t st_r;

  cost_t   sym_tab_r   [N_STATES][N_SYMBOLS];
  cost_t   trans_tab_r [N_STATES][N_STATES];
  cost_t   init_tab_r  [N_STATES];
  cost_t   fin_tab_r   [N_STATES];
  metric_t pm_r        [N_STATES];
  metric_t fin_r       [N_STATES];
  logic [BP_ROW_W-1:0] fbp_r;

  logic [CNT_W-1:0]  cnt_r;
  logic              in_seq_r, drop_r;

  logic [BP_ROW_W-1:0] bp_mem [MAX_LEN];
  logic [BP_ROW_W-1:0] rdata_r;
  logic                bp_we, bp_re;
  logic [ADDR_W-1:0]   bp_waddr, bp_raddr;

  logic [STATE_W-1:0] cur_r, cur_sel;
  logic               rd_pend_r, tr_ovf_r;
  logic [ADDR_W-1:0]  pos_r;

  out_item_t  oq_r [2];
  logic       owr_r, ord_r;
  logic [1:0] ocnt_r;
  logic       opush, opop;
  out_item_t  onew;

  metric_t                   pm_src   [N_STATES];
  logic signed [METRIC_BITS:0] acs_best [N_STATES];
  logic [BP_ROW_W-1:0]       acs_bp;
  logic signed [METRIC_BITS:0] c;
  logic [STATE_W-1:0]        pick;
  metric_t                   pick_v;

  assign cmd_take     = (st_r == ST_IDLE) && cmd_valid;
  assign stat.tracing = (st_r == ST_TRACE);
  assign stat.take    = cmd_take;

  // Add-compare-select over all states; strict less-than keeps the lowest state.
  always_comb begin
    for (int s = 0; s < N_STATES; s++) begin
      pm_src[s] = in_seq_r ? pm_r[s] : {{EXT_W{init_tab_r[s][COST_BITS-1]}}, init_tab_r[s]};
    end
    acs_bp = '0;
    c      = '0;
    for (int ns = 0; ns < N_STATES; ns++) begin
      acs_best[ns] = {pm_src[0][METRIC_BITS-1], pm_src[0]}
                   + {{(EXT_W+1){trans_tab_r[0][ns][COST_BITS-1]}}, trans_tab_r[0][ns]};
      acs_bp[ns*STATE_W +: STATE_W] = '0;
      for (int os = 1; os < N_STATES; os++) begin
        c = {pm_src[os][METRIC_BITS-1], pm_src[os]}
          + {{(EXT_W+1){trans_tab_r[os][ns][COST_BITS-1]}}, trans_tab_r[os][ns]};
        if (c < acs_best[ns]) begin
          acs_best[ns] = c;
          acs_bp[ns*STATE_W +: STATE_W] = STATE_W'(os);
        end
      end
    end
  end

  // Cheapest end state after final costs.
  always_comb begin
    pick   = '0;
    pick_v = fin_r[0];
    for (int s = 1; s < N_STATES; s++) begin
      if (fin_r[s] < pick_v) begin
        pick_v = fin_r[s];
        pick   = STATE_W'(s);
      end
    end
  end

  assign cur_sel  = rd_pend_r ? rdata_r[cur_r*STATE_W +: STATE_W] : cur_r;
  assign bp_waddr = cnt_r[ADDR_W-1:0];
  assign bp_we    = cmd_take && (cmd.op == OP_SYMBOL) && (cnt_r < CNT_W'(MAX_LEN));
  assign bp_re    = (st_r == ST_TRACE) && (ocnt_r != 2'd2) && (pos_r != '0);
  assign bp_raddr = pos_r;
  assign opush    = (st_r == ST_TRACE) && (ocnt_r != 2'd2);
  assign opop     = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = oq_r[ord_r];

  always_comb begin
    onew.label_state = cur_sel;
    onew.position    = POS_W'(pos_r);
    onew.last_label  = (pos_r == '0);
    onew.overflow    = tr_ovf_r;
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= acs_bp;
    end
    if (bp_re) begin
      rdata_r <= bp_mem[bp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      oq_r[owr_r] <= onew;
    end
  end

  // Path metrics and final sums need no reset: written before read.
  always_ff @(posedge clk) begin
    if (bp_we) begin
      for (int s = 0; s < N_STATES; s++) begin
        pm_r[s] <= acs_best[s][METRIC_BITS-1:0]
                 + ((int'(cmd.sym) < N_SYMBOLS) ?
                    {{EXT_W{sym_tab_r[s][cmd.sym][COST_BITS-1]}}, sym_tab_r[s][cmd.sym]}
                    : metric_t'(0));
      end
    end
    if (st_r == ST_FINAL) begin
      for (int s = 0; s < N_STATES; s++) begin
        fin_r[s] <= acs_best[s][METRIC_BITS-1:0]
                  + {{EXT_W{fin_tab_r[s][COST_BITS-1]}}, fin_tab_r[s]};
      end
      fbp_r <= acs_bp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      in_seq_r  <= 1'b0;
      drop_r    <= 1'b0;
      cur_r     <= '0;
      rd_pend_r <= 1'b0;
      tr_ovf_r  <= 1'b0;
      pos_r     <= '0;
      owr_r     <= 1'b0;
      ord_r     <= 1'b0;
      ocnt_r    <= 2'd0;
      for (int r = 0; r < N_STATES; r++) begin
        init_tab_r[r] <= '0;
        fin_tab_r[r]  <= '0;
        for (int k = 0; k < N_SYMBOLS; k++) begin
          sym_tab_r[r][k] <= '0;
        end
        for (int k = 0; k < N_STATES; k++) begin
          trans_tab_r[r][k] <= '0;
        end
      end
    end else begin
      if (opush) begin
        owr_r <= ~owr_r;
      end
      if (opop) begin
        ord_r <= ~ord_r;
      end
      case ({opush, opop})
        2'b10:   ocnt_r <= ocnt_r + 2'd1;
        2'b01:   ocnt_r <= ocnt_r - 2'd1;
        default: ocnt_r <= ocnt_r;
      endcase

      unique case (st_r)
        ST_IDLE: begin
          if (cmd_take) begin
            unique case (cmd.op)
              OP_LOAD_SYM: begin
                if (int'(cmd.row) < N_STATES && int'(cmd.col) < N_SYMBOLS) begin
                  sym_tab_r[cmd.row][cmd.col] <= cmd.cost;
                end
              end
              OP_LOAD_TRANS: begin
                if (int'(cmd.row) < N_STATES && int'(cmd.col) < N_STATES) begin
                  trans_tab_r[cmd.row][cmd.col] <= cmd.cost;
                end
              end
              OP_LOAD_INIT: begin
                if (int'(cmd.row) < N_STATES) begin
                  init_tab_r[cmd.row] <= cmd.cost;
                end
              end
              OP_LOAD_FINAL: begin
                if (int'(cmd.row) < N_STATES) begin
                  fin_tab_r[cmd.row] <= cmd.cost;
                end
              end
              OP_SYMBOL: begin
                in_seq_r <= 1'b1;
                if (bp_we) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  drop_r <= 1'b1;
                end
                if (cmd.last) begin
                  st_r <= ST_FINAL;
                end
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
        ST_FINAL: begin
          // Capture the last position and overflow flag, then close the sequence.
          pos_r    <= ADDR_W'(cnt_r - CNT_W'(1));
          tr_ovf_r <= drop_r;
          cnt_r    <= '0;
          in_seq_r <= 1'b0;
          drop_r   <= 1'b0;
          st_r     <= ST_PICK;
        end
        ST_PICK: begin
          cur_r     <= fbp_r[pick*STATE_W +: STATE_W];
          rd_pend_r <= 1'b0;
          st_r      <= ST_TRACE;
        end
        ST_TRACE: begin
          cur_r <= cur_sel;
          if (opush) begin
            rd_pend_r <= bp_re;
            if (pos_r == '0) begin
              st_r <= ST_IDLE;
            end else begin
              pos_r <= pos_r - ADDR_W'(1);
            end
          end else begin
            rd_pend_r <= 1'b0;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/viterbi_min_cost_path_decoder_unit.sv =====
// Top level of the min-cost path decoder: front end, back end and checks.
// Depends on vmcp_pkg, vmcp_front and vmcp_back.
`timescale 1ns / 1ps
// Min-cost Viterbi labeller. Push load items to fill the symbol, transition,
// initial and final cost tables, then push symbol items; each symbol takes one
// add-compare-select step in the back end and stores one backpointer row.
// The symbol marked last is followed by a final transition step (ST_FINAL) and
// a pick of the cheapest end state (ST_PICK), then the traceback emits
// one label per cycle, from the last position down to zero, limited by the
// single read port of the backpointer memory and by result pops.
// A two-entry command queue lets the input side keep pushing while labels
// drain, and a two-entry result queue decouples pops from the traceback.
// Symbols past MAX_LEN are dropped and set overflow on every label of the
// sequence; reserved modes are dropped at the input.
module viterbi_min_cost_path_decoder_unit #(
  parameter int MAX_LEN = vmcp_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  vmcp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output vmcp_pkg::out_item_t out_item
);
  import vmcp_pkg::*;

  logic        cmd_valid, cmd_take;
  cmd_t        cmd;
  front_stat_t fstat;
  back_stat_t  bstat;

  // Decode and queue incoming items.
  vmcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .stat      (fstat)
  );

  // Execute commands and trace back.
  vmcp_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .stat      (bstat)
  );

  // Hold commands back while a traceback runs.
  a_no_take_in_trace: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.tracing |-> !bstat.take) else $error("command taken during traceback");

  // Command queue never exceeds its depth.
  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count != 2'd3) else $error("command queue overrun");

  // A symbol pushed into an empty queue is offered next cycle.
  a_symbol_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_item.mode == MODE_SYMBOL && fstat.count == 2'd0)
    |=> cmd_valid) else $error("symbol item lost in front end");

endmodule

// ===== bench/tb.sv =====
// Testbench for the min-cost path decoder: loads cost tables, streams symbol
// sequences and checks every label against an in-bench path decoder.
// Depends on vmcp_pkg and viterbi_min_cost_path_decoder_unit.
`timescale 1ns / 1ps
module tb;
  import vmcp_pkg::*;

  localparam int MAXL = MAX_LEN_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  always #5 clk = ~clk;

  viterbi_min_cost_path_decoder_unit dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item),
    .in_full(in_full), .out_empty(out_empty), .out_pop(out_pop),
    .out_item(out_item)
  );

  // Decoder state mirrored in the bench.
  cost_t   sym_cost [N_STATES][N_SYMBOLS];
  cost_t   trans_cost [N_STATES][N_STATES];
  cost_t   init_cost [N_STATES];
  cost_t   end_cost [N_STATES];
  metric_t metric [N_STATES];
  logic [1:0] backptr [MAXL][N_STATES];
  int      seq_len;
  bit      seq_open;
  bit      seq_dropped;

  in_item_t  pending_items [$];
  out_item_t expected_labels [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int idle_cycles = 0;

  // Add-compare-select over all states; lowest state wins ties.
  task automatic add_compare_select(output metric_t nxt [N_STATES],
                                    output logic [1:0] bp [N_STATES]);
    metric_t c;
    for (int ns = 0; ns < N_STATES; ns++) begin
      nxt[ns] = metric[0] + metric_t'(trans_cost[0][ns]);
      bp[ns] = 2'd0;
      for (int os = 1; os < N_STATES; os++) begin
        c = metric[os] + metric_t'(trans_cost[os][ns]);
        if (c < nxt[ns]) begin
          nxt[ns] = c;
          bp[ns] = os[1:0];
        end
      end
    end
  endtask

  // Advance the mirrored decoder by one item and queue the labels it yields.
  task automatic predict_labels(input in_item_t it);
    metric_t nxt [N_STATES];
    logic [1:0] bp [N_STATES];
    metric_t v, best;
    logic [1:0] cur;
    out_item_t r;
    case (it.mode)
      MODE_LOAD_SYM:   sym_cost[it.row_index][it.col_index] = it.cost_value;
      MODE_LOAD_TRANS: trans_cost[it.row_index][it.col_index] = it.cost_value;
      MODE_LOAD_INIT:  init_cost[it.row_index] = it.cost_value;
      MODE_LOAD_FINAL: end_cost[it.row_index] = it.cost_value;
      MODE_SYMBOL: begin
        if (!seq_open) begin
          for (int s = 0; s < N_STATES; s++) metric[s] = metric_t'(init_cost[s]);
          seq_len = 0;
          seq_dropped = 1'b0;
          seq_open = 1'b1;
        end
        if (seq_len < MAXL) begin
          add_compare_select(nxt, bp);
          for (int s = 0; s < N_STATES; s++) begin
            backptr[seq_len][s] = bp[s];
            metric[s] = nxt[s] + metric_t'(sym_cost[s][it.symbol]);
          end
          seq_len++;
        end else begin
          seq_dropped = 1'b1;
        end
        if (it.last_symbol) begin
          add_compare_select(nxt, bp);
          cur = 2'd0;
          best = nxt[0] + metric_t'(end_cost[0]);
          for (int s = 1; s < N_STATES; s++) begin
            v = nxt[s] + metric_t'(end_cost[s]);
            if (v < best) begin
              best = v;
              cur = s[1:0];
            end
          end
          if (seq_len > 0) cur = bp[cur];
          for (int p = seq_len - 1; p >= 0; p--) begin
            r.label_state = cur;
            r.position = p[5:0];
            r.last_label = (p == 0);
            r.overflow = seq_dropped;
            expected_labels.push_back(r);
            if (p > 0) cur = backptr[p][cur];
          end
          seq_len = 0;
          seq_open = 1'b0;
          seq_dropped = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Driver: hold the item until accepted, idle at random between items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_labels(in_item);
        void'(pending_items.pop_front());
      end
      if ((!in_push || !in_full) && pending_items.size() > 0
          && $urandom_range(99) >= idle_pct) begin
        in_push <= 1'b1;
        in_item <= pending_items[0];
      end else if (!in_push || !in_full) begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped label with the oldest expected one.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_labels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected label %p", out_item);
        end else begin
          e = expected_labels.pop_front();
          if (out_item !== e) begin
            errors++;
            if (errors <= 10) $display("label mismatch: expected %p, got %p", e, out_item);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [2:0] m, input logic [1:0] sy,
                                         input logic [1:0] r, input logic [1:0] c,
                                         input logic [15:0] v, input logic l);
    in_item_t it;
    it.mode = m; it.symbol = sy; it.row_index = r; it.col_index = c;
    it.cost_value = v; it.last_symbol = l;
    return it;
  endfunction

  // Queue a sequence of random symbols, ending with the last flag.
  task automatic push_sequence(input int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(make_item(MODE_SYMBOL, 2'($urandom_range(3)),
                                        2'($urandom_range(3)), 2'($urandom_range(3)),
                                        16'($urandom), i == n - 1));
  endtask

  // Queue a random table load or a reserved mode item.
  task automatic push_noise();
    logic [2:0] m;
    m = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
    pending_items.push_back(make_item(m, 2'($urandom_range(3)), 2'($urandom_range(3)),
                                      2'($urandom_range(3)), 16'($urandom),
                                      1'($urandom_range(1))));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_push || expected_labels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < N_STATES; s++) begin
      init_cost[s] = '0;
      end_cost[s] = '0;
      for (int t = 0; t < N_STATES; t++) begin
        sym_cost[s][t] = '0;
        trans_cost[s][t] = '0;
      end
    end
    seq_len = 0;
    seq_open = 1'b0;
    seq_dropped = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero tie case, extreme costs, every load mode, overflow.
    pending_items.push_back(make_item(MODE_SYMBOL, 2'd0, 2'd0, 2'd0, 16'h0, 1'b1));
    pending_items.push_back(make_item(MODE_LOAD_SYM, 2'd3, 2'd3, 2'd3, 16'h7fff, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_SYM, 2'd1, 2'd0, 2'd2, 16'h8000, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_TRANS, 2'd0, 2'd3, 2'd1, 16'h8000, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_TRANS, 2'd0, 2'd1, 2'd2, 16'h7fff, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_INIT, 2'd0, 2'd2, 2'd0, 16'hffff, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_FINAL, 2'd0, 2'd1, 2'd0, 16'h8000, 1'b0));
    pending_items.push_back(make_item(3'd5, 2'd1, 2'd1, 2'd1, 16'h1234, 1'b1));
    pending_items.push_back(make_item(3'd7, 2'd3, 2'd3, 2'd3, 16'hffff, 1'b0));
    pending_items.push_back(make_item(MODE_SYMBOL, 2'd3, 2'd0, 2'd0, 16'h0, 1'b0));
    pending_items.push_back(make_item(MODE_LOAD_SYM, 2'd0, 2'd2, 2'd3, 16'h0100, 1'b0));
    pending_items.push_back(make_item(MODE_SYMBOL, 2'd2, 2'd0, 2'd0, 16'h0, 1'b1));
    push_sequence(MAXL + 3);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 17) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 47 : 17) : 0;
      for (int k = 0; k < 20; ) begin
        if ($urandom_range(3) == 0) begin
          push_noise();
          k++;
        end else begin
          int n;
          n = ($urandom_range(15) == 0) ? $urandom_range(MAXL - 2, MAXL + 2)
                                        : $urandom_range(1, 6);
          push_sequence(n);
          k += (n > 8) ? 8 : n;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== viterbi_min_cost_path_decoder_unit.f =====
src/vmcp_pkg.sv
src/vmcp_front.sv
src/vmcp_back.sv
src/viterbi_min_cost_path_decoder_unit.sv
bench/tb.sv
